// ----- rtl/dial_gesture_remapper_defines.svh -----
// assertion macros used by the checker file dgr_checker.sv
`ifndef DIAL_GESTURE_REMAPPER_DEFINES_SVH
`define DIAL_GESTURE_REMAPPER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DGR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dgr assertion failed");

// next-cycle implication, disabled while in reset
`define DGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dgr assertion failed");

`endif

// ----- rtl/dgr_pkg.sv -----
// types, codes and helpers of the dial gesture remapper
package dgr_pkg;

  // input opcodes
  localparam logic [1:0] OP_USAGE     = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_LINK_LOST = 2'd2;

  // result actions
  localparam logic [1:0] ACT_CONSUMER = 2'd0;
  localparam logic [1:0] ACT_KEYBOARD = 2'd1;
  localparam logic [1:0] ACT_WAKEUP   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TAP_WINDOW    = 2'd0;
  localparam logic [1:0] CFG_MODE_HOLD     = 2'd1;
  localparam logic [1:0] CFG_RELEASE_DELAY = 2'd2;
  localparam logic [1:0] CFG_FINE_MODS     = 2'd3;

  localparam logic [15:0] TAP_WINDOW_RST    = 16'd500;
  localparam logic [15:0] MODE_HOLD_RST     = 16'd1000;
  localparam logic [7:0]  RELEASE_DELAY_RST = 8'd5;
  localparam logic        FINE_MODS_RST     = 1'b1;

  // consumer usages
  localparam logic [7:0] U_MUTE       = 8'hE2;
  localparam logic [7:0] U_PLAY_PAUSE = 8'hCD;
  localparam logic [7:0] U_SCAN_NEXT  = 8'hB5;
  localparam logic [7:0] U_SCAN_PREV  = 8'hB6;
  localparam logic [7:0] U_VOL_UP     = 8'hE9;
  localparam logic [7:0] U_VOL_DOWN   = 8'hEA;
  localparam logic [7:0] U_BRIGHT_UP  = 8'h6F;
  localparam logic [7:0] U_BRIGHT_DN  = 8'h70;

  // keyboard modifiers and keys
  localparam logic [7:0] MOD_NONE = 8'h00;
  localparam logic [7:0] MOD_FINE = 8'h06;
  localparam logic [7:0] MOD_LOCK = 8'h09;
  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_Q    = 8'h14;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] usage;
    logic       host_suspended;
    logic       host_ready;
  } dgr_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] consumer_usage;
    logic [7:0]  key_modifiers;
    logic [7:0]  key_code;
    logic        last_of_run;
  } dgr_out_t;

  typedef struct packed {
    logic [15:0] tap_span_ms;
    logic [15:0] hold_ext_ms;
    logic [7:0]  release_delay_ms;
    logic        fine_mods;
  } dgr_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] mode_deadline;
    logic [31:0] release_deadline;
    logic        dial_is_track;
    logic        consumer_held;
    logic        keyboard_held;
    logic        input_pressed;
    logic        mode_used;
  } dgr_state_t;

  function automatic dgr_out_t mk_res(logic [1:0] act, logic [15:0] cu,
                                      logic [7:0] mods, logic [7:0] key);
    dgr_out_t r;
    r.action         = act;
    r.consumer_usage = cu;
    r.key_modifiers  = mods;
    r.key_code       = key;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/dgr_step.sv -----
// gesture decode and timing for one request: next state and up to three results
module dgr_step import dgr_pkg::*; (
  input  dgr_in_t    item_i,
  input  dgr_cfg_t   cfg_i,
  input  dgr_state_t st_i,
  output dgr_state_t st_o,
  output dgr_out_t   res_o [MaxResults],
  output logic [CntW-1:0] cnt_o
);

  always_comb begin
    dgr_state_t      s;
    logic [CntW-1:0] n;
    logic            do_send;
    logic [7:0]      send_usage;
    logic            send_fine;
    logic            up;
    logic [31:0]     diff;
    logic            rdy;

    s          = st_i;
    n          = '0;
    do_send    = 1'b0;
    send_usage = 8'h00;
    send_fine  = 1'b0;
    up         = (item_i.usage == U_VOL_UP);
    rdy        = item_i.host_ready;
    diff       = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res_o[i] = '0;
    end

    case (item_i.opcode)
      OP_USAGE: begin
        if (item_i.usage == 8'h00) begin
          s.input_pressed = 1'b0;
        end else if (!st_i.input_pressed) begin
          s.input_pressed = 1'b1;
          if (item_i.host_suspended) begin
            res_o[n] = mk_res(ACT_WAKEUP, 16'h0000, MOD_NONE, KEY_NONE);
            n = n + 1'b1;
          end else if (item_i.usage inside {U_MUTE, U_PLAY_PAUSE}) begin
            s.dial_is_track = (item_i.usage == U_PLAY_PAUSE);
            s.mode_deadline = st_i.now_ms + {16'h0000, cfg_i.tap_span_ms};
            s.mode_used     = 1'b0;
          end else if (item_i.usage == U_SCAN_NEXT) begin
            s.mode_deadline = '0;
            if (rdy) begin
              res_o[n] = mk_res(ACT_KEYBOARD, 16'h0000, MOD_LOCK, KEY_Q);
              n = n + 1'b1;
              s.keyboard_held    = 1'b1;
              s.release_deadline = st_i.now_ms + {24'h000000, cfg_i.release_delay_ms};
            end
          end else if (item_i.usage inside {U_VOL_UP, U_VOL_DOWN}) begin
            diff    = st_i.mode_deadline - st_i.now_ms;
            do_send = 1'b1;
            // window still open: deadline strictly ahead of now
            if (st_i.mode_deadline != '0 && !diff[31] && diff != '0) begin
              s.mode_used     = 1'b1;
              s.mode_deadline = st_i.now_ms + {16'h0000, cfg_i.hold_ext_ms};
              if (!st_i.dial_is_track) begin
                send_usage = up ? U_BRIGHT_UP : U_BRIGHT_DN;
                send_fine  = cfg_i.fine_mods;
              end else begin
                send_usage = up ? U_SCAN_NEXT : U_SCAN_PREV;
              end
            end else begin
              s.mode_deadline = '0;
              send_usage      = up ? U_VOL_UP : U_VOL_DOWN;
              send_fine       = cfg_i.fine_mods;
            end
          end
        end
      end
      OP_TICK: begin
        s.now_ms = st_i.now_ms + 32'd1;
        diff = s.now_ms - st_i.release_deadline;
        if ((st_i.consumer_held || st_i.keyboard_held) && !diff[31] && rdy) begin
          if (st_i.consumer_held) begin
            res_o[n] = mk_res(ACT_CONSUMER, 16'h0000, MOD_NONE, KEY_NONE);
            s.consumer_held = 1'b0;
          end else begin
            res_o[n] = mk_res(ACT_KEYBOARD, 16'h0000, MOD_NONE, KEY_NONE);
            s.keyboard_held = 1'b0;
          end
          n = n + 1'b1;
        end
        diff = s.now_ms - st_i.mode_deadline;
        if (st_i.mode_deadline != '0 && !diff[31]) begin
          // window expired unused: plain mute or play/pause
          if (!st_i.mode_used) begin
            do_send    = 1'b1;
            send_usage = st_i.dial_is_track ? U_PLAY_PAUSE : U_MUTE;
          end
          s.mode_deadline = '0;
        end
      end
      OP_LINK_LOST: begin
        s.input_pressed = 1'b0;
      end
      default: begin
      end
    endcase

    // consumer send, with modifier report first when needed
    if (do_send && rdy) begin
      if (send_fine || s.keyboard_held) begin
        res_o[n] = mk_res(ACT_KEYBOARD, 16'h0000, send_fine ? MOD_FINE : MOD_NONE,
                          KEY_NONE);
        n = n + 1'b1;
        s.keyboard_held = send_fine;
      end
      res_o[n] = mk_res(ACT_CONSUMER, {8'h00, send_usage}, MOD_NONE, KEY_NONE);
      n = n + 1'b1;
      s.consumer_held    = 1'b1;
      s.release_deadline = s.now_ms + {24'h000000, cfg_i.release_delay_ms};
    end

    if (n != '0) begin
      res_o[n - 1'b1].last_of_run = 1'b1;
    end

    st_o  = s;
    cnt_o = n;
  end

endmodule

// ----- rtl/dial_gesture_remapper.sv -----
// Dial gesture remapper: turns pod usage bytes, millisecond ticks and link-loss
// requests into consumer, keyboard and remote wakeup results. A request is held in
// the input register until the result register is free, then the step logic writes
// its next state and all of its results (zero to three) into the result register at
// once. The result register drains one result per cycle while out_ready_i is high, and
// takes the next request's results as its last result leaves, so requests with at
// most one result stream at one per cycle while the output is ready. Configuration
// writes are registered; the user must make them only while the block is idle, and
// the block itself does not enforce this.
module dial_gesture_remapper import dgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dgr_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dgr_out_t    out_data_o
);

  dgr_cfg_t        cfg_q;
  dgr_state_t      st_q, st_d;
  dgr_in_t         item_q;
  logic            item_vld_q;
  dgr_out_t        res_q [MaxResults];
  dgr_out_t        res_d [MaxResults];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            batch_load;
  logic            pop;

  dgr_step u_step (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d),
    .cnt_o  (cnt_d)
  );

  assign pop         = out_valid_o && out_ready_i;
  // result register frees up when empty or when its last result leaves now
  assign batch_load  = item_vld_q && (cnt_q == '0 || (cnt_q == CntW'(1) && out_ready_i));
  assign in_ready_o  = !item_vld_q || batch_load;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = res_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_span_ms      <= TAP_WINDOW_RST;
      cfg_q.hold_ext_ms      <= MODE_HOLD_RST;
      cfg_q.release_delay_ms <= RELEASE_DELAY_RST;
      cfg_q.fine_mods        <= FINE_MODS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAP_WINDOW:    cfg_q.tap_span_ms      <= cfg_data_i;
        CFG_MODE_HOLD:     cfg_q.hold_ext_ms      <= cfg_data_i;
        CFG_RELEASE_DELAY: cfg_q.release_delay_ms <= cfg_data_i[7:0];
        CFG_FINE_MODS:     cfg_q.fine_mods        <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_vld_q <= 1'b1;
    end else if (batch_load) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      cnt_q <= '0;
    end else if (batch_load) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_load) begin
      res_q <= res_d;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_q[i] <= res_q[i + 1];
      end
    end
  end

endmodule

// ----- rtl/dgr_checker.sv -----
// port-level checks of the dial gesture remapper, bound to the top level
`include "dial_gesture_remapper_defines.svh"

module dgr_checker import dgr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input dgr_out_t out_data_o
);

  `DGR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `DGR_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_valid_o && out_ready_i && !out_data_o.last_of_run, out_valid_o)
  `DGR_ASSERT_IMPL(a_wakeup_alone, clk_i, rst_ni, out_valid_o && out_data_o.action == ACT_WAKEUP, out_data_o.last_of_run)
  `DGR_ASSERT_IMPL(a_usage_consumer_only, clk_i, rst_ni, out_valid_o && out_data_o.action != ACT_CONSUMER, out_data_o.consumer_usage == 16'h0000)

endmodule

bind dial_gesture_remapper dgr_checker u_dgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
